>>> hdl/fflrf_pkg.sv
// ----------------------------------------------------------------------------
// fflrf_pkg: shared definitions of the FFT length radix factorizer
// Radix table, exact-division inverses, status codes and the command and
// status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package fflrf_pkg;

	// Defaults of the top-level parameters.
	localparam int DEFAULT_LENGTH_BITS = 32;
	localparam int DEFAULT_MAX_STAGES  = 32;

	// Fixed field widths of the result items.
	localparam int LENGTH_W    = 32;
	localparam int RADIX_W     = 5;
	localparam int INDEX_W     = 5;
	localparam int STATUS_W    = 2;

	// Radix set, tried in ascending order.
	localparam int RADIX_COUNT = 8;
	localparam int PTR_W       = 3;

	localparam logic [RADIX_W-1:0] RADIX_VALUE [RADIX_COUNT] = '{
		5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19
	};

	// Multiplicative inverses modulo 2^32 of the odd radices. The entry of
	// radix two is not used: that radix is tested on the low bit.
	localparam logic [LENGTH_W-1:0] RADIX_INV [RADIX_COUNT] = '{
		32'h0000_0001, 32'hAAAA_AAAB, 32'hCCCC_CCCD, 32'hB6DB_6DB7,
		32'hBA2E_8BA3, 32'hC4EC_4EC5, 32'hF0F0_F0F1, 32'h286B_CA1B
	};

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_LEFTOVER = 2'd1,
		STATUS_EMPTY    = 2'd2,
		STATUS_ZERO     = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;        // capture a new length, clear pointer and count
		logic    mul;         // form the exact-division product
		logic    take;        // divide by the current radix and record the stage
		logic    next_radix;  // move on to the next radix
		logic    set_err;     // mark the item as an error with err_code
		status_t err_code;
		logic    start_emit;  // point at the first stage
		logic    adv_emit;    // point at the next stage
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic rem_zero;
		logic rem_one;
		logic divisible;
		logic full;
		logic ptr_last;
		logic count_zero;
		logic emit_last;
		logic err;
	} dp_stat_t;

endpackage

>>> hdl/fflrf_if.sv
// ----------------------------------------------------------------------------
// fflrf_if: channel interfaces of the FFT length radix factorizer
// Valid/ready channels for the transform lengths and the radix results.
// ----------------------------------------------------------------------------
interface fflrf_len_if;
	logic                           valid;
	logic                           ready;
	logic [fflrf_pkg::LENGTH_W-1:0] fft_length;

	modport source (output valid, output fft_length, input ready);
	modport sink (input valid, input fft_length, output ready);
endinterface

interface fflrf_res_if;
	logic                           valid;
	logic                           ready;
	logic [fflrf_pkg::RADIX_W-1:0]  radix;
	logic [fflrf_pkg::INDEX_W-1:0]  stage_index;
	logic                           is_last;
	logic [fflrf_pkg::STATUS_W-1:0] status;

	modport source (output valid, output radix, output stage_index, output is_last,
		output status, input ready);
	modport sink (input valid, input radix, input stage_index, input is_last,
		input status, output ready);
endinterface

>>> hdl/fflrf_datapath.sv
// ----------------------------------------------------------------------------
// fflrf_datapath: trial-division datapath
// Holds the remaining value, the radix pointer and the stage list, tests
// divisibility by exact-division multiplication and forms the result fields.
// ----------------------------------------------------------------------------
module fflrf_datapath #(
	parameter int LENGTH_BITS = fflrf_pkg::DEFAULT_LENGTH_BITS,
	parameter int MAX_STAGES  = fflrf_pkg::DEFAULT_MAX_STAGES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fflrf_pkg::dp_cmd_t             cmd,
	output fflrf_pkg::dp_stat_t            stat,
	input  logic [fflrf_pkg::LENGTH_W-1:0] fft_length,
	output logic [fflrf_pkg::RADIX_W-1:0]  radix,
	output logic [fflrf_pkg::INDEX_W-1:0]  stage_index,
	output logic                           is_last,
	output logic [fflrf_pkg::STATUS_W-1:0] status
);

	localparam int L  = LENGTH_BITS;
	localparam int IW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int CW = $clog2(MAX_STAGES + 1);
	localparam logic [L-1:0] MASK = {L{1'b1}};

	// Largest quotient an exact division by each radix can give.
	localparam logic [L-1:0] DIV_LIMIT [fflrf_pkg::RADIX_COUNT] = '{
		MASK >> 1, MASK / 3, MASK / 5, MASK / 7,
		MASK / 11, MASK / 13, MASK / 17, MASK / 19
	};

	logic [L-1:0]                  rem_q;
	logic [L-1:0]                  prod_q;
	logic [fflrf_pkg::PTR_W-1:0]   ptr_q;
	logic [CW-1:0]                 count_q;
	logic [IW-1:0]                 idx_q;
	logic                          err_q;
	fflrf_pkg::status_t            err_code_q;
	logic [fflrf_pkg::PTR_W-1:0]   stage_q [MAX_STAGES];

	logic [L-1:0]                  prod_low;
	logic [L-1:0]                  inv;
	logic                          divisible;
	logic [L-1:0]                  quotient;

	// Exact-division product: for an odd radix the low half equals the
	// quotient whenever the radix divides the value.
	assign inv      = fflrf_pkg::RADIX_INV[ptr_q][L-1:0];
	assign prod_low = rem_q * inv;

	// Divisibility test and quotient; radix two works on the low bit.
	always_comb begin
		if (ptr_q == '0) begin
			divisible = ~rem_q[0];
			quotient  = rem_q >> 1;
		end else begin
			divisible = (prod_q <= DIV_LIMIT[ptr_q]);
			quotient  = prod_q;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q      <= '0;
			ptr_q      <= '0;
			count_q    <= '0;
			idx_q      <= '0;
			err_q      <= 1'b0;
			err_code_q <= fflrf_pkg::STATUS_OK;
		end else begin
			if (cmd.load) begin
				rem_q   <= fft_length[L-1:0];
				ptr_q   <= '0;
				count_q <= '0;
				err_q   <= 1'b0;
			end
			if (cmd.take) begin
				rem_q   <= quotient;
				count_q <= count_q + CW'(1);
			end
			if (cmd.next_radix) begin
				ptr_q <= ptr_q + fflrf_pkg::PTR_W'(1);
			end
			if (cmd.set_err) begin
				err_q      <= 1'b1;
				err_code_q <= cmd.err_code;
			end
			if (cmd.start_emit) begin
				idx_q <= '0;
			end
			if (cmd.adv_emit) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	// Product register and stage list.
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= prod_low;
		end
		if (cmd.take) begin
			stage_q[count_q[IW-1:0]] <= ptr_q;
		end
	end

	// Status toward the controller.
	always_comb begin
		stat.rem_zero   = (rem_q == '0);
		stat.rem_one    = (rem_q == L'(1));
		stat.divisible  = divisible;
		stat.full       = (count_q == CW'(MAX_STAGES));
		stat.ptr_last   = (ptr_q == fflrf_pkg::PTR_W'(fflrf_pkg::RADIX_COUNT - 1));
		stat.count_zero = (count_q == '0);
		stat.emit_last  = (CW'(idx_q) + CW'(1) == count_q);
		stat.err        = err_q;
	end

	// Result fields; an error result carries its status, with is_last set and zero radix and index.
	always_comb begin
		if (err_q) begin
			radix       = '0;
			stage_index = '0;
			is_last     = 1'b1;
			status      = err_code_q;
		end else begin
			radix       = fflrf_pkg::RADIX_VALUE[stage_q[idx_q]];
			stage_index = fflrf_pkg::INDEX_W'(idx_q);
			is_last     = stat.emit_last;
			status      = fflrf_pkg::STATUS_OK;
		end
	end

endmodule

>>> hdl/fflrf_controller.sv
// ----------------------------------------------------------------------------
// fflrf_controller: sequencer of the FFT length radix factorizer
// Steps the datapath through multiply and check cycles per radix trial and
// then hands out the results one transfer at a time.
// ----------------------------------------------------------------------------
module fflrf_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output fflrf_pkg::dp_cmd_t  cmd,
	input  fflrf_pkg::dp_stat_t stat
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_CHK  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);

	// Next state and datapath commands.
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.err_code   = fflrf_pkg::STATUS_OK;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				if (stat.rem_zero) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = fflrf_pkg::STATUS_ZERO;
					state_d      = ST_EMIT;
				end else begin
					cmd.mul = 1'b1;
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				if (!stat.rem_one && stat.divisible) begin
					if (stat.full) begin
						// Stage budget spent while a radix still divides.
						cmd.set_err  = 1'b1;
						cmd.err_code = fflrf_pkg::STATUS_LEFTOVER;
						state_d      = ST_EMIT;
					end else begin
						cmd.take = 1'b1;
						state_d  = ST_MUL;
					end
				end else if (!stat.rem_one && !stat.ptr_last) begin
					cmd.next_radix = 1'b1;
					state_d        = ST_MUL;
				end else begin
					// Factoring is over: decide between the list and an error.
					state_d = ST_EMIT;
					if (!stat.rem_one) begin
						cmd.set_err  = 1'b1;
						cmd.err_code = fflrf_pkg::STATUS_LEFTOVER;
					end else if (stat.count_zero) begin
						cmd.set_err  = 1'b1;
						cmd.err_code = fflrf_pkg::STATUS_EMPTY;
					end else begin
						cmd.start_emit = 1'b1;
					end
				end
			end
			ST_EMIT: begin
				if (out_ready) begin
					if (stat.err || stat.emit_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.adv_emit = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hdl/fft_length_radix_factorizer_core.sv
// ----------------------------------------------------------------------------
// fft_length_radix_factorizer_core: mixed-radix FFT length factorizer
// Splits a transform length into the radices 2,3,5,7,11,13,17,19 in
// ascending order and returns one result per stage, or a single error.
//
//   Channel   Dir  Payload                                  Transfer when
//   lengths   in   fft_length[31:0]                         valid && ready
//   results   out  radix[4:0] stage_index[4:0] is_last      valid && ready
//                  status[1:0]
//
// Each trial is a multiply step and then a check step, with one trial per
// stage found and one per radix tried; a zero length goes to its error
// straight from the multiply step. Results then go out one per cycle while
// the results channel is ready, and the next length can be taken in the
// cycle after the last result transfer. The registered exact-division
// product splits each trial into its multiply and check steps.
// Reset is asynchronous, active low, and returns the block to idle.
// A stalled results channel holds the current result; lengths are taken
// only while no item is in progress.
// ----------------------------------------------------------------------------
module fft_length_radix_factorizer_core #(
	parameter int LENGTH_BITS = fflrf_pkg::DEFAULT_LENGTH_BITS,
	parameter int MAX_STAGES  = fflrf_pkg::DEFAULT_MAX_STAGES
) (
	input logic         clk,
	input logic         arst_n,
	fflrf_len_if.sink   lengths,
	fflrf_res_if.source results
);

	fflrf_pkg::dp_cmd_t  cmd;
	fflrf_pkg::dp_stat_t stat;

	// Sequencer.
	fflrf_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (lengths.valid),
		.in_ready  (lengths.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Trial-division datapath.
	fflrf_datapath #(
		.LENGTH_BITS (LENGTH_BITS),
		.MAX_STAGES  (MAX_STAGES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.fft_length  (lengths.fft_length),
		.radix       (results.radix),
		.stage_index (results.stage_index),
		.is_last     (results.is_last),
		.status      (results.status)
	);

endmodule

>>> verif/fft_length_radix_factorizer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fft_length_radix_factorizer_core_tb: self-checking bench of the factorizer
// Feeds directed and random transform lengths, predicts the radix stage list
// or the error result of each accepted length, and checks every result
// transfer in order. Sender gaps and receiver stalls vary by phase, and one
// long receiver hold-off makes the block back up onto its input.
// ----------------------------------------------------------------------------
module fft_length_radix_factorizer_core_tb;

	localparam int LENGTH_BITS = fflrf_pkg::DEFAULT_LENGTH_BITS;
	localparam int MAX_STAGES  = fflrf_pkg::DEFAULT_MAX_STAGES;
	localparam int LW = fflrf_pkg::LENGTH_W;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 150;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int RANDOM_PER_PHASE = 62;
	localparam int DIRECTED_COUNT = 24;

	// Extremes, each radix alone, the longest stage lists and the error cases.
	localparam logic [LW-1:0] DIRECTED_LENGTHS [DIRECTED_COUNT] = '{
		32'd0, 32'd1, 32'd2, 32'd3, 32'd5, 32'd7, 32'd11, 32'd13, 32'd17, 32'd19,
		32'h8000_0000, 32'hFFFF_FFFF, 32'd23, 32'd3486784401, 32'd893871739,
		32'd9699690, 32'd1000, 32'd4096, 32'hC000_0000, 32'd410338673,
		32'd46, 32'hFFFF_FFFE, 32'd6, 32'd121
	};

	// Primes outside the radix set, used to leave a leftover factor.
	localparam logic [LW-1:0] FOREIGN_PRIMES [6] = '{
		32'd23, 32'd29, 32'd31, 32'd37, 32'd257, 32'd65537
	};

	typedef struct packed {
		logic [LW-1:0]                  fft_length;
		logic [fflrf_pkg::RADIX_W-1:0]  radix;
		logic [fflrf_pkg::INDEX_W-1:0]  stage_index;
		logic                           is_last;
		fflrf_pkg::status_t             status;
	} stage_result_t;

	// Holds the stage results still owed by the block and checks arrivals.
	class stage_scoreboard;
		stage_result_t owed_stages[$];
		int            mismatch_count;

		function new();
			mismatch_count = 0;
		endfunction

		function void owe_error(logic [LW-1:0] len, fflrf_pkg::status_t code);
			stage_result_t e;
			e.fft_length  = len;
			e.radix       = '0;
			e.stage_index = '0;
			e.is_last     = 1'b1;
			e.status      = code;
			owed_stages   = {owed_stages, e};
		endfunction

		// Factor the accepted length by trial division and queue its results.
		function void note_length(logic [LW-1:0] len);
			logic [LW-1:0]                 rest;
			logic [fflrf_pkg::RADIX_W-1:0] found[$];
			logic                          overflow;
			stage_result_t                 e;
			rest = len;
			overflow = 1'b0;
			if (rest == '0) begin
				owe_error(len, fflrf_pkg::STATUS_ZERO);
				return;
			end
			for (int k = 0; k < fflrf_pkg::RADIX_COUNT; k++) begin
				while (!overflow && (rest % fflrf_pkg::RADIX_VALUE[k]) == 0) begin
					if (found.size() >= MAX_STAGES) begin
						overflow = 1'b1;
					end else begin
						rest  = rest / fflrf_pkg::RADIX_VALUE[k];
						found = {found, fflrf_pkg::RADIX_VALUE[k]};
					end
				end
			end
			if (overflow || rest != 1) begin
				owe_error(len, fflrf_pkg::STATUS_LEFTOVER);
			end else if (found.size() == 0) begin
				owe_error(len, fflrf_pkg::STATUS_EMPTY);
			end else begin
				for (int k = 0; k < found.size(); k++) begin
					e.fft_length  = len;
					e.radix       = found[k];
					e.stage_index = k[fflrf_pkg::INDEX_W-1:0];
					e.is_last     = (k == found.size() - 1);
					e.status      = fflrf_pkg::STATUS_OK;
					owed_stages   = {owed_stages, e};
				end
			end
		endfunction

		// Compare one result transfer with the oldest owed result.
		function void check_result(logic [fflrf_pkg::RADIX_W-1:0] radix,
			logic [fflrf_pkg::INDEX_W-1:0] idx, logic last,
			logic [fflrf_pkg::STATUS_W-1:0] status);
			stage_result_t e;
			if (owed_stages.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected result radix %0d index %0d last %0b status %0d",
						$realtime, radix, idx, last, status);
				return;
			end
			e = owed_stages.pop_front();
			if (radix !== e.radix || idx !== e.stage_index || last !== e.is_last ||
				status !== e.status) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$write("%0t: length %0d expected radix %0d index %0d last %0b status %0d,",
						$realtime, e.fft_length, e.radix, e.stage_index, e.is_last,
						e.status);
					$display(" got radix %0d index %0d last %0b status %0d",
						radix, idx, last, status);
				end
			end
		endfunction

		function int pending();
			return owed_stages.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	fflrf_len_if lengths_ch ();
	fflrf_res_if results_ch ();

	fft_length_radix_factorizer_core #(
		.LENGTH_BITS(LENGTH_BITS),
		.MAX_STAGES (MAX_STAGES)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.lengths(lengths_ch.sink),
		.results(results_ch.source)
	);

	stage_scoreboard board = new();

	int send_idle_pct;
	int recv_stall_pct;
	int hold_request;
	int hold_left;
	int cycle_count;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	initial begin
		results_ch.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_ch.ready <= 1'b0;
			end else begin
				results_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Note each accepted length and check each result transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (lengths_ch.valid && lengths_ch.ready)
				board.note_length(lengths_ch.fft_length);
			if (results_ch.valid && results_ch.ready)
				board.check_result(results_ch.radix, results_ch.stage_index,
					results_ch.is_last, results_ch.status);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offer one length, with random gaps first; called and left at a falling edge.
	task automatic send_length(input logic [LW-1:0] len);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			lengths_ch.valid <= 1'b0;
			@(negedge clk);
		end
		lengths_ch.valid      <= 1'b1;
		lengths_ch.fft_length <= len;
		@(posedge clk);
		while (!lengths_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// A length built only from supported radices, often with long stage lists.
	function automatic logic [LW-1:0] factorable_length();
		logic [63:0]                   acc;
		logic [fflrf_pkg::RADIX_W-1:0] r;
		int                            top;
		acc = 64'd1;
		top = $urandom_range(0, fflrf_pkg::RADIX_COUNT - 1);
		repeat ($urandom_range(1, 31)) begin
			r = fflrf_pkg::RADIX_VALUE[$urandom_range(0, top)];
			if (acc * r <= 64'hFFFF_FFFF)
				acc = acc * r;
		end
		return acc[LW-1:0];
	endfunction

	// Mostly factorable lengths, some with a foreign factor, some raw noise.
	function automatic logic [LW-1:0] random_length();
		logic [63:0] acc;
		int          pick;
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			return factorable_length();
		end else if (pick < 80) begin
			acc = {32'd0, factorable_length()} * FOREIGN_PRIMES[$urandom_range(0, 5)];
			if (acc > 64'hFFFF_FFFF)
				acc = FOREIGN_PRIMES[$urandom_range(0, 5)] * $urandom_range(1, 64);
			return acc[LW-1:0];
		end else if (pick < 95) begin
			return $urandom;
		end else begin
			return $urandom_range(0, 1);
		end
	endfunction

	task automatic run_phase(input int send_pct, input int stall_pct, input int count);
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		repeat (count)
			send_length(random_length());
	endtask

	// Stimulus and end of run.
	initial begin
		arst_n = 1'b0;
		lengths_ch.valid = 1'b0;
		lengths_ch.fft_length = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 0;
		cycle_count = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed lengths with no idling on either side.
		foreach (DIRECTED_LENGTHS[k])
			send_length(DIRECTED_LENGTHS[k]);

		// Long receiver hold-off while the sender keeps offering lengths.
		hold_request = HOLD_OFF_CYCLES;
		run_phase(0, 0, RANDOM_PER_PHASE);
		run_phase(50, 0, RANDOM_PER_PHASE);
		run_phase(0, 50, RANDOM_PER_PHASE);
		run_phase(26, 26, RANDOM_PER_PHASE);
		lengths_ch.valid <= 1'b0;

		// Drain, then allow for any work still in flight.
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.mismatch_count == 0 && board.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
